FILE: hdl/fspa_pkg.sv
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; imported by fixed_slot_pool_allocator_unit.

package fspa_pkg;

   // Fixed field widths of the request, response and CSR ports
   localparam int SLOT_W      = 9;
   localparam int OFFSET_W    = 25;
   localparam int ARENAS_W    = 4;
   localparam int STATUS_W    = 2;
   localparam int OBJ_W       = 16;
   localparam int HDR_W       = 5;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNOPENED  = 2'd2;

   // CSR indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_BYTES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTES = 1'd1;

   // Reset values of the CSRs
   localparam logic [OBJ_W-1:0] OBJ_RESET = 16'd16;
   localparam logic [HDR_W-1:0] HDR_RESET = 5'd16;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DIV       = 8'b0000_0010,
      S_FREE_RD   = 8'b0000_0100,
      S_FREE_CHK  = 8'b0000_1000,
      S_ALLOC_RD  = 8'b0001_0000,
      S_ALLOC_CHK = 8'b0010_0000,
      S_MUL       = 8'b0100_0000,
      S_RESP      = 8'b1000_0000
   } state_type;

endpackage

FILE: hdl/fixed_slot_pool_allocator_unit.sv
// Fixed slot pool allocator: free bitmap memory, scan sequencer, offset multiply.
// Depends on fspa_pkg.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------------
//  request | req_kind, req_slot                     | taken when start && !busy
//  result  | rsp_status, rsp_granted_slot,          | rsp_valid high for one cycle,
//          | rsp_byte_offset, rsp_arenas_open       | no back-pressure
//  csr     | csr_write_en, csr_index, csr_wdata     | written on any edge with write_en
//
// Allocate: each arena word is read from the bitmap memory (one read port,
// registered read) and checked in turn, then the offset is multiplied and summed
// before rsp_valid; an empty pool goes straight to the multiply. Free: one
// compare-subtract per arena to split the slot number, then a read-modify-write.
// One request at a time; busy is high until the result cycle. Sync reset empties
// the pool at once; bitmap words are written in full when an arena opens.

module fixed_slot_pool_allocator_unit
   import fspa_pkg::*;
#(
   parameter int SLOTS_PER_ARENA = 40,
   parameter int MAX_ARENAS      = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic [SLOT_W-1:0]      req_slot,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_W-1:0]      rsp_granted_slot,
   output logic [OFFSET_W-1:0]    rsp_byte_offset,
   output logic [ARENAS_W-1:0]    rsp_arenas_open,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
   localparam int CW = $clog2(MAX_ARENAS + 1);
   localparam int BW = (SLOTS_PER_ARENA > 1) ? $clog2(SLOTS_PER_ARENA) : 1;
   localparam int SW = (SLOTS_PER_ARENA * MAX_ARENAS > 1) ?
                       $clog2(SLOTS_PER_ARENA * MAX_ARENAS) : 1;
   localparam int PW = SW + OBJ_W + 1;
   localparam int OW = PW + 1;

   localparam logic [SW-1:0]              SPA_SLOT  = SW'(SLOTS_PER_ARENA);
   localparam logic [SLOT_W-1:0]          SPA_REQ   = SLOT_W'(SLOTS_PER_ARENA);
   localparam logic [CW-1:0]              MAX_CNT   = CW'(MAX_ARENAS);
   localparam logic [SLOTS_PER_ARENA-1:0] WORD_ONE  = SLOTS_PER_ARENA'(1);
   localparam logic [SLOTS_PER_ARENA-1:0] WORD_OPEN = ~WORD_ONE;

   // Bitmap memory: one word per arena, 1 = slot free
   logic [SLOTS_PER_ARENA-1:0] free_map_mem [MAX_ARENAS];
   logic [SLOTS_PER_ARENA-1:0] rd_word_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [SLOTS_PER_ARENA-1:0] mem_wd;

   state_type             state_ff, state_in;
   logic [OBJ_W-1:0]      obj_ff, obj_in;
   logic [HDR_W-1:0]      hdr_ff, hdr_in;
   logic [CW-1:0]         open_ff, open_in;
   logic [SLOT_W-1:0]     req_slot_ff, req_slot_in;
   logic [SLOT_W-1:0]     rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         arena_ff, arena_in;
   logic [SW-1:0]         base_ff, base_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [ARENAS_W-1:0]   rsp_open_ff, rsp_open_in;

   // Lowest free slot in the word just read
   logic          word_found;
   logic [BW-1:0] word_first;

   always_comb begin
      word_found = |rd_word_ff;
      word_first = '0;
      for (int i = SLOTS_PER_ARENA - 1; i >= 0; i--) begin
         if (rd_word_ff[i]) begin
            word_first = BW'(i);
         end
      end
   end

   always_comb begin
      obj_in = obj_ff;
      hdr_in = hdr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OBJECT_BYTES: obj_in = csr_wdata;
            CSR_HEADER_BYTES: hdr_in = csr_wdata[HDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      open_in       = open_ff;
      req_slot_in   = req_slot_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      arena_in      = arena_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_open_in   = rsp_open_ff;
      mem_we        = 1'b0;
      mem_wa        = arena_ff;
      mem_wd        = rd_word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_slot_in = req_slot;
               if (req_kind == KIND_FREE) begin
                  rem_in   = req_slot;
                  cnt_in   = '0;
                  state_in = S_DIV;
               end else if (open_ff == '0) begin
                  // empty pool: open arena 0 and take its first slot
                  mem_we   = 1'b1;
                  mem_wa   = '0;
                  mem_wd   = WORD_OPEN;
                  slot_in  = '0;
                  open_in  = open_ff + CW'(1);
                  state_in = S_MUL;
               end else begin
                  arena_in = '0;
                  base_in  = '0;
                  state_in = S_ALLOC_RD;
               end
            end
         end

         S_DIV: begin
            if (cnt_ff == open_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_UNOPENED;
               rsp_slot_in   = '0;
               rsp_offset_in = '0;
               rsp_open_in   = ARENAS_W'(open_ff);
               state_in      = S_IDLE;
            end else if (rem_ff < SPA_REQ) begin
               arena_in = cnt_ff[AW-1:0];
               state_in = S_FREE_RD;
            end else begin
               rem_in = rem_ff - SPA_REQ;
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_FREE_RD: state_in = S_FREE_CHK;

         S_FREE_CHK: begin
            mem_we        = 1'b1;
            mem_wa        = arena_ff;
            mem_wd        = rd_word_ff | (WORD_ONE << rem_ff[BW-1:0]);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_slot_in   = req_slot_ff;
            rsp_offset_in = '0;
            rsp_open_in   = ARENAS_W'(open_ff);
            state_in      = S_IDLE;
         end

         S_ALLOC_RD: state_in = S_ALLOC_CHK;

         S_ALLOC_CHK: begin
            if (word_found) begin
               mem_we   = 1'b1;
               mem_wa   = arena_ff;
               mem_wd   = rd_word_ff & ~(WORD_ONE << word_first);
               slot_in  = base_ff + SW'(word_first);
               state_in = S_MUL;
            end else if (CW'(arena_ff) + CW'(1) == open_ff) begin
               if (open_ff == MAX_CNT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EXHAUSTED;
                  rsp_slot_in   = '0;
                  rsp_offset_in = '0;
                  rsp_open_in   = ARENAS_W'(open_ff);
                  state_in      = S_IDLE;
               end else begin
                  // all open arenas full: open the next one
                  mem_we   = 1'b1;
                  mem_wa   = open_ff[AW-1:0];
                  mem_wd   = WORD_OPEN;
                  slot_in  = base_ff + SPA_SLOT;
                  open_in  = open_ff + CW'(1);
                  state_in = S_MUL;
               end
            end else begin
               arena_in = arena_ff + AW'(1);
               base_in  = base_ff + SPA_SLOT;
               state_in = S_ALLOC_RD;
            end
         end

         S_MUL: begin
            prod_in  = PW'(slot_ff) * (PW'(hdr_ff) + PW'(obj_ff));
            state_in = S_RESP;
         end

         S_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_slot_in   = SLOT_W'(slot_ff);
            rsp_offset_in = OFFSET_W'(OW'(prod_ff) + OW'(hdr_ff));
            rsp_open_in   = ARENAS_W'(open_ff);
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_map_mem[mem_wa] <= mem_wd;
      end
      rd_word_ff <= free_map_mem[arena_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         obj_ff       <= OBJ_RESET;
         hdr_ff       <= HDR_RESET;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         obj_ff       <= obj_in;
         hdr_ff       <= hdr_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_slot_ff   <= req_slot_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      arena_ff      <= arena_in;
      base_ff       <= base_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_open_ff   <= rsp_open_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_byte_offset  = rsp_offset_ff;
   assign rsp_arenas_open  = rsp_open_ff;

endmodule
